/* rtl/jad_pkg.sv */
`timescale 1ns / 1ps

package jad_pkg;

    localparam int SAMPLE_BITS_DEF = 12;
    localparam int TIME_BITS_DEF   = 32;

    // configuration register widths
    localparam int AXIS_CFG_W = 12;
    localparam int HOLD_CFG_W = 16;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 2;

    localparam logic [AXIS_CFG_W-1:0] CENTER_X_RST = 12'd1878;
    localparam logic [AXIS_CFG_W-1:0] CENTER_Y_RST = 12'd1773;
    localparam logic [AXIS_CFG_W-1:0] DEADZONE_RST = 12'd300;
    localparam logic [HOLD_CFG_W-1:0] LONG_MS_RST  = 16'd800;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CENTER_X = 2'd0,
        CFG_CENTER_Y = 2'd1,
        CFG_DEADZONE = 2'd2,
        CFG_LONG_MS  = 2'd3
    } t_cfg_index;

    typedef enum logic [2:0] {
        ACT_NONE  = 3'd0,
        ACT_PRESS = 3'd1,
        ACT_LONG  = 3'd2,
        ACT_UP    = 3'd3,
        ACT_DOWN  = 3'd4,
        ACT_LEFT  = 3'd5,
        ACT_RIGHT = 3'd6
    } t_action;

endpackage

/* rtl/joystick_action_detector.sv */
`timescale 1ns / 1ps

// channel   direction  handshake                  payload
// in        input      i_in_valid / o_in_stall    i_x_sample, i_y_sample,
//                                                 i_button_level, i_now_ms
// out       output     o_out_valid / i_out_stall  o_action
// cfg       input      i_cfg_we                   i_cfg_index, i_cfg_wdata
//
// one transaction per cycle unless stalled; input register, then result register
// the poll state (press time, button level, long flag, last direction) updates
// as a poll moves from the input register to the result register
// synchronous active-low reset clears control state and loads register defaults
// a stall on the output holds the result register, and the input stalls only
// when both registers are full

module joystick_action_detector
    import jad_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int TIME_BITS   = TIME_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,

    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic [SAMPLE_BITS-1:0] i_x_sample,
    input  logic [SAMPLE_BITS-1:0] i_y_sample,
    input  logic                   i_button_level,
    input  logic [TIME_BITS-1:0]   i_now_ms,

    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic [2:0]             o_action,

    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_wdata
);

    localparam int MAG_W  = (SAMPLE_BITS > AXIS_CFG_W) ? SAMPLE_BITS : AXIS_CFG_W;
    localparam int DIFF_W = MAG_W + 1;

    // configuration
    logic [AXIS_CFG_W-1:0] r_center_x, r_center_y, r_deadzone;
    logic [HOLD_CFG_W-1:0] r_long_ms;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center_x <= CENTER_X_RST;
            r_center_y <= CENTER_Y_RST;
            r_deadzone <= DEADZONE_RST;
            r_long_ms  <= LONG_MS_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_CENTER_X: r_center_x <= i_cfg_wdata[AXIS_CFG_W-1:0];
                CFG_CENTER_Y: r_center_y <= i_cfg_wdata[AXIS_CFG_W-1:0];
                CFG_DEADZONE: r_deadzone <= i_cfg_wdata[AXIS_CFG_W-1:0];
                CFG_LONG_MS:  r_long_ms  <= i_cfg_wdata[HOLD_CFG_W-1:0];
                default: ;
            endcase
        end
    end

    // pipeline control
    logic r_in_valid, r_out_valid;
    logic advance;

    assign advance    = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_in_valid && !advance;

    logic [SAMPLE_BITS-1:0] r_x, r_y;
    logic                   r_level;
    logic [TIME_BITS-1:0]   r_now;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_x     <= i_x_sample;
            r_y     <= i_y_sample;
            r_level <= i_button_level;
            r_now   <= i_now_ms;
        end
    end

    // poll state
    logic [TIME_BITS-1:0] r_press_start, n_press_start;
    logic                 r_button_prev, n_button_prev;
    logic                 r_long_reported, n_long_reported;
    t_action              r_last_dir, n_last_dir;
    t_action              r_action, n_action;

    logic signed [DIFF_W-1:0] dx, dy;
    logic [MAG_W-1:0]         ax, ay;
    logic [TIME_BITS-1:0]     held;
    logic                     button_event;
    t_action                  dir;

    always_comb begin
        dx = $signed({1'b0, MAG_W'(r_x)}) - $signed({1'b0, MAG_W'(r_center_x)});
        dy = $signed({1'b0, MAG_W'(r_y)}) - $signed({1'b0, MAG_W'(r_center_y)});
        ax = dx[DIFF_W-1] ? MAG_W'(-dx) : MAG_W'(dx);
        ay = dy[DIFF_W-1] ? MAG_W'(-dy) : MAG_W'(dy);
        held = r_now - r_press_start;

        if (ax > ay) begin
            dir = dx[DIFF_W-1] ? ACT_DOWN : ACT_UP;
        end else begin
            dir = (!dy[DIFF_W-1] && dy != '0) ? ACT_LEFT : ACT_RIGHT;
        end

        n_press_start   = r_press_start;
        n_long_reported = r_long_reported;
        n_button_prev   = r_level;
        n_last_dir      = r_last_dir;
        n_action        = ACT_NONE;
        button_event    = 1'b0;

        if (!r_level && r_button_prev) begin
            n_press_start   = r_now;
            n_long_reported = 1'b0;
        end
        if (!r_level && !r_button_prev && !r_long_reported
                && held > TIME_BITS'(r_long_ms)) begin
            n_long_reported = 1'b1;
            n_action        = ACT_LONG;
            button_event    = 1'b1;
        end
        if (r_level && !r_button_prev && !r_long_reported) begin
            n_action     = ACT_PRESS;
            button_event = 1'b1;
        end

        if (!button_event) begin
            if (ax > MAG_W'(r_deadzone) || ay > MAG_W'(r_deadzone)) begin
                if (dir != r_last_dir) begin
                    n_last_dir = dir;
                    n_action   = dir;
                end
            end else begin
                n_last_dir = ACT_NONE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid     <= 1'b0;
            r_button_prev   <= 1'b1;
            r_long_reported <= 1'b0;
            r_last_dir      <= ACT_NONE;
            r_press_start   <= '0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
            if (r_in_valid) begin
                r_button_prev   <= n_button_prev;
                r_long_reported <= n_long_reported;
                r_last_dir      <= n_last_dir;
                r_press_start   <= n_press_start;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_valid) begin
            r_action <= n_action;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_action    = r_action;

`ifndef SYNTHESIS
    // remembered direction is center or one of the four directions
    a_last_dir_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_last_dir == ACT_NONE || r_last_dir == ACT_UP || r_last_dir == ACT_DOWN
        || r_last_dir == ACT_LEFT || r_last_dir == ACT_RIGHT)
        else $error("last direction holds a non-direction code");

    a_long_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_action == ACT_LONG) |-> r_long_reported)
        else $error("long press shown without long flag set");

    a_press_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_action == ACT_PRESS) |-> (r_button_prev && !r_long_reported))
        else $error("press shown while button not released");

    a_dir_tracked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_action == ACT_UP || r_action == ACT_DOWN
            || r_action == ACT_LEFT || r_action == ACT_RIGHT)) |-> r_last_dir == r_action)
        else $error("direction shown differs from remembered direction");

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_out_valid && i_out_stall))
        else $error("input stalled while result register can drain");
`endif

endmodule
